[src/gld_pkg.sv]
// Shared types, constants and the grey conversion of the 3x3 line detector.
// No dependencies; used by the modules of the block by scoped names, except gld_ram.
`default_nettype none
package gld_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned CFG_W = 12;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] MIN_SIZE     = 12'd3;

  localparam logic [9:0] GREY_K0 = 10'd307;
  localparam logic [9:0] GREY_K1 = 10'd604;
  localparam logic [9:0] GREY_K2 = 10'd113;
  localparam int unsigned GREY_SHIFT = 10;
  localparam int unsigned GREY_SUM_W = 18;

  localparam logic [PIX_W-1:0] CLAMP_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] byte_first;
    logic [PIX_W-1:0] byte_second;
    logic [PIX_W-1:0] byte_third;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] line_value;
    logic             frame_last;
  } line_out_t;

  typedef struct packed {
    logic [PIX_W-1:0] grey;
    logic             interior;
    logic             last;
  } stage_t;

  function automatic logic [PIX_W-1:0] grey_of(input pix_in_t p);
    logic [GREY_SUM_W-1:0] s;
    s = GREY_SUM_W'(GREY_K0) * GREY_SUM_W'(p.byte_first)
      + GREY_SUM_W'(GREY_K1) * GREY_SUM_W'(p.byte_second)
      + GREY_SUM_W'(GREY_K2) * GREY_SUM_W'(p.byte_third);
    return s[GREY_SHIFT +: PIX_W];
  endfunction

endpackage
`default_nettype wire

[src/grey_line_detect_3x3_unit.sv]
// Top level of the 3x3 grey line detector: config registers, handshake, line RAM.
// Depends on gld_pkg, gld_ram, gld_front and gld_kernel.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one colour pixel per item,
//   in raster order. The output channel out_valid/out_ready/out_data carries
//   one clamped 45-degree line response per interior pixel; border pixels give
//   no item. frame_last marks the final interior result of a frame.
//   The APB port holds image_width (0x0) and image_height (0x4); a write to
//   either restarts the frame at row 0, column 0. Write only while idle.
//   Throughput: one pixel per clock unless out_ready stalls the output, set by
//   the single-port-pair line RAM, read at accept and written at stage advance.
//   A pixel that completes its window is registered in the pixel stage, with
//   the RAM read at accept, then its result in the output register that
//   drives out_valid; a stall on out_ready can hold it between the two.
//   When out_ready is low, one more pixel is held in the inner stage; after
//   that in_ready drops until the output item is taken.
//   Reset clears counters, handshake state and loads width 640, height 480.
//   Line RAM contents are not cleared; a word only feeds a result after being
//   written within the same frame.
`default_nettype none
module grey_line_detect_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire gld_pkg::pix_in_t          in_data,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      gld_pkg::line_out_t        out_data,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned LW = 2 * gld_pkg::PIX_W;

  logic [gld_pkg::CFG_W-1:0] width_r, width_nxt;
  logic [gld_pkg::CFG_W-1:0] height_r, height_nxt;
  logic                      cfg_we;

  logic                      accept, s1_adv, s1_valid;
  gld_pkg::stage_t           s1_info;
  logic [CW-1:0]             s1_col, rd_col;
  logic [LW-1:0]             line_rdata, line_wdata;
  logic [gld_pkg::PIX_W-1:0] kernel_value;

  logic                      out_valid_r, out_valid_nxt;
  gld_pkg::line_out_t        out_data_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (paddr[2])
        gld_pkg::REG_WIDTH:  width_nxt  = pwdata[gld_pkg::CFG_W-1:0];
        gld_pkg::REG_HEIGHT: height_nxt = pwdata[gld_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gld_pkg::REG_WIDTH:  prdata = 32'(width_r);
      gld_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:             prdata = '0;
    endcase
  end

  assign s1_adv   = s1_valid && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  gld_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .in_data    (in_data),
    .accept     (accept),
    .advance    (s1_adv),
    .s1_valid   (s1_valid),
    .s1_info    (s1_info),
    .s1_col     (s1_col),
    .rd_col     (rd_col)
  );

  // word holds {row r-2, row r-1}; write back {row r-1, current row}
  assign line_wdata = {line_rdata[gld_pkg::PIX_W-1:0], s1_info.grey};

  gld_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (line_wdata),
    .re    (accept),
    .raddr (rd_col),
    .rdata (line_rdata)
  );

  gld_kernel u_kernel (
    .clk        (clk),
    .advance    (s1_adv),
    .top_g      (line_rdata[LW-1:gld_pkg::PIX_W]),
    .mid_g      (line_rdata[gld_pkg::PIX_W-1:0]),
    .bot_g      (s1_info.grey),
    .line_value (kernel_value)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_info.interior) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= gld_pkg::WIDTH_RESET;
      height_r    <= gld_pkg::HEIGHT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_info.interior) begin
      out_data_r.line_value <= kernel_value;
      out_data_r.frame_last <= s1_info.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[src/gld_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module gld_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[src/gld_front.sv]
// Accept stage: raster counters, grey conversion and the held pixel stage.
// Depends on gld_pkg.
`default_nettype none
module gld_front #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          restart,
  input  wire logic [gld_pkg::CFG_W-1:0]     width_cfg,
  input  wire logic [gld_pkg::CFG_W-1:0]     height_cfg,
  input  wire gld_pkg::pix_in_t              in_data,
  input  wire logic                          accept,
  input  wire logic                          advance,
  output      logic                          s1_valid,
  output      gld_pkg::stage_t               s1_info,
  output      logic [$clog2(MAX_WIDTH)-1:0]  s1_col,
  output      logic [$clog2(MAX_WIDTH)-1:0]  rd_col
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = gld_pkg::CFG_W + 1;

  logic [CW-1:0]             col_r, col_nxt;
  logic [gld_pkg::CFG_W-1:0] row_r, row_nxt;
  logic                      s1_v_r, s1_v_nxt;
  gld_pkg::stage_t           s1_info_r;
  logic [CW-1:0]             s1_col_r;

  logic [WW-1:0]             eff_w;
  logic [gld_pkg::CFG_W-1:0] eff_h;
  logic [WW-1:0]             col_inc;
  logic [RW-1:0]             row_inc;
  logic                      col_end, row_end;
  gld_pkg::stage_t           info_in;

  always_comb begin
    if (width_cfg < gld_pkg::MIN_SIZE) begin
      eff_w = WW'(gld_pkg::MIN_SIZE);
    end else if (32'(width_cfg) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(32'(MAX_WIDTH));
    end else begin
      eff_w = WW'(width_cfg);
    end
    if (height_cfg < gld_pkg::MIN_SIZE) begin
      eff_h = gld_pkg::MIN_SIZE;
    end else begin
      eff_h = height_cfg;
    end
  end

  always_comb begin
    col_inc = WW'(col_r) + WW'(1);
    row_inc = RW'(row_r) + RW'(1);
    col_end = (col_inc >= eff_w);
    row_end = (row_inc >= RW'(eff_h));
    info_in.grey     = gld_pkg::grey_of(in_data);
    info_in.interior = (row_r >= gld_pkg::CFG_W'(2)) && (col_r >= CW'(2));
    info_in.last     = col_end && row_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_inc[gld_pkg::CFG_W-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info_in;
      s1_col_r  <= col_r;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_info  = s1_info_r;
  assign s1_col   = s1_col_r;
  assign rd_col   = col_r;

endmodule
`default_nettype wire

[src/gld_kernel.sv]
// 3x3 window columns and the clamped 45-degree line kernel.
// Depends on gld_pkg.
`default_nettype none
module gld_kernel (
  input  wire logic                      clk,
  input  wire logic                      advance,
  input  wire logic [gld_pkg::PIX_W-1:0] top_g,
  input  wire logic [gld_pkg::PIX_W-1:0] mid_g,
  input  wire logic [gld_pkg::PIX_W-1:0] bot_g,
  output      logic [gld_pkg::PIX_W-1:0] line_value
);

  logic [gld_pkg::PIX_W-1:0] tl_r, ml_r, bl_r;
  logic [gld_pkg::PIX_W-1:0] tc_r, mc_r, bc_r;

  logic [10:0]        pos_sum, neg_sum;
  logic signed [12:0] v;

  always_comb begin
    pos_sum = (11'(top_g) + 11'(mc_r) + 11'(bl_r)) << 1;
    neg_sum = 11'(tl_r) + 11'(tc_r) + 11'(ml_r) + 11'(mid_g) + 11'(bc_r) + 11'(bot_g);
    v = $signed({2'b00, pos_sum}) - $signed({2'b00, neg_sum});
    if (v[12]) begin
      line_value = '0;
    end else if (|v[11:8]) begin
      line_value = gld_pkg::CLAMP_MAX;
    end else begin
      line_value = v[7:0];
    end
  end

  // shift window left by one column
  always_ff @(posedge clk) begin
    if (advance) begin
      tl_r <= tc_r;
      ml_r <= mc_r;
      bl_r <= bc_r;
      tc_r <= top_g;
      mc_r <= mid_g;
      bc_r <= bot_g;
    end
  end

endmodule
`default_nettype wire

[src/gld_checker.sv]
// Port-level checks of the 3x3 grey line detector, bound to the top level.
// Depends on gld_pkg and grey_line_detect_3x3_unit.
`default_nettype none
module gld_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire gld_pkg::line_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register is empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output item present right after reset");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rst_n))
    else $error("output item appeared out of reset");

endmodule

bind grey_line_detect_3x3_unit gld_checker u_gld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
